// ===== rtl/waveform_oscillator_nco_assert.svh =====
// Assertion macros for the waveform oscillator RTL.
`ifndef WAVEFORM_OSCILLATOR_NCO_ASSERT_SVH
`define WAVEFORM_OSCILLATOR_NCO_ASSERT_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define WNCO_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("wnco assertion failed");
// Condition must never be true outside reset.
`define WNCO_ASSERT_NEVER(label, clk_sig, rst_sig, cond) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) \
        else $error("wnco forbidden condition seen");
`else
`define WNCO_ASSERT(label, clk_sig, rst_sig, prop)
`define WNCO_ASSERT_NEVER(label, clk_sig, rst_sig, cond)
`endif
`endif

// ===== rtl/wnco_pkg.sv =====
// Shared types and codes for the waveform oscillator.
package wnco_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM        = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INCREMENT = 2'd1;

    localparam logic [2:0] WAVE_TRIANGLE = 3'd0;
    localparam logic [2:0] WAVE_SAWTOOTH = 3'd1;
    localparam logic [2:0] WAVE_SINE     = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;
    localparam logic [2:0] WAVE_QUARTER  = 3'd4;
    localparam logic [2:0] WAVE_EIGHTH   = 3'd5;

    localparam logic [2:0]  WAVEFORM_RESET  = WAVE_TRIANGLE;
    localparam logic [31:0] PHASE_INC_RESET = 32'd39370533;

    typedef struct packed {
        logic restart_phase;
        logic end_of_block;
    } tick_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_in_block;
    } wave_t;

endpackage

// ===== rtl/wnco_sine_rom.sv =====
// Quarter-wave sine ROM with registered read.
module wnco_sine_rom
    import wnco_pkg::*;
#(
    parameter int ADDR_BITS = 10
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [ADDR_BITS:0]   addr,
    output logic [14:0]          data
);

    localparam int DEPTH = (1 << ADDR_BITS) + 1;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int RECIP_SHIFT = 40;

    // reciprocals of the series divisors (2n)(2n+1); exact for dividends below 2^32
    localparam logic [39:0] TAYLOR_RECIP [1:7] = '{
        40'((64'd1 << RECIP_SHIFT) / 64'd6 + 64'd1),
        40'((64'd1 << RECIP_SHIFT) / 64'd20 + 64'd1),
        40'((64'd1 << RECIP_SHIFT) / 64'd42 + 64'd1),
        40'((64'd1 << RECIP_SHIFT) / 64'd72 + 64'd1),
        40'((64'd1 << RECIP_SHIFT) / 64'd110 + 64'd1),
        40'((64'd1 << RECIP_SHIFT) / 64'd156 + 64'd1),
        40'((64'd1 << RECIP_SHIFT) / 64'd210 + 64'd1)
    };

    typedef logic [14:0] sine_rom_t [DEPTH];

    // Taylor series of sin in Q30, terms up to x^15, truncating divides
    function automatic logic [14:0] sine_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        logic [79:0]     prod;
        x    = (HALF_PI_Q30 * longint'(k)) >> ADDR_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            prod = 80'((term * x2) >> 30) * 80'(TAYLOR_RECIP[n]);
            term = 64'(prod >> RECIP_SHIFT);
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
        if (v > 32767)
            v = 32767;
        return v[14:0];
    endfunction

    function automatic sine_rom_t build_rom();
        sine_rom_t r;
        for (int k = 0; k < DEPTH; k++)
            r[k] = sine_entry(k);
        return r;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    logic [14:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

// ===== rtl/wnco_shape.sv =====
// Waveform shaping from a 32-bit phase fraction.
module wnco_shape
    import wnco_pkg::*;
(
    input  logic [2:0]          sel,
    input  logic [31:0]         q,
    input  logic [14:0]         sine_mag,
    output logic signed [15:0]  sample
);

    localparam logic [31:0] QUARTER  = 32'h4000_0000;
    localparam logic [31:0] THREE_QT = 32'hC000_0000;
    localparam logic [48:0] ROUND32  = 49'h0_8000_0000;

    logic [48:0]        tri_rise_prod;
    logic [48:0]        tri_fall_prod;
    logic [48:0]        saw_prod;
    logic [31:0]        q_minus_h;
    logic [31:0]        q_minus_3h;
    logic [16:0]        tri_tail;
    logic signed [17:0] tri_rise;
    logic signed [17:0] tri_fall;
    logic signed [17:0] tri_end;
    logic signed [17:0] saw;
    logic signed [15:0] tri_val;
    logic signed [15:0] sine_val;

    assign q_minus_h     = q - QUARTER;
    assign q_minus_3h    = q - THREE_QT;
    assign tri_rise_prod = {17'd0, q} * 49'd131068 + ROUND32;
    assign tri_fall_prod = {17'd0, q_minus_h} * 49'd131070 + ROUND32;
    assign saw_prod      = {17'd0, q} * 49'd65535 + ROUND32;
    assign tri_tail      = 17'((33'(q_minus_3h) + 33'd16384) >> 15);

    assign tri_rise = signed'({2'b00, tri_rise_prod[47:32]});
    assign tri_fall = 18'sd32767 - signed'({2'b00, tri_fall_prod[47:32]});
    assign tri_end  = signed'({1'b0, tri_tail}) - 18'sd32768;
    assign saw      = signed'({2'b00, saw_prod[47:32]}) - 18'sd32768;

    always_comb
    begin
        if (q <= QUARTER)
            tri_val = tri_rise[15:0];
        else if (q >= THREE_QT)
            tri_val = tri_end[15:0];
        else
            tri_val = tri_fall[15:0];
    end

    // upper half of the cycle is the negated quarter-wave
    assign sine_val = q[31] ? -signed'({1'b0, sine_mag}) : signed'({1'b0, sine_mag});

    always_comb
    begin
        case (sel)
            WAVE_TRIANGLE: sample = tri_val;
            WAVE_SAWTOOTH: sample = saw[15:0];
            WAVE_SINE:     sample = sine_val;
            WAVE_SQUARE:   sample = (q < 32'h8000_0000) ? 16'sh7fff : 16'sh8000;
            WAVE_QUARTER:  sample = (q < 32'h4000_0000) ? 16'sh7fff : 16'sh8000;
            WAVE_EIGHTH:   sample = (q < 32'h2000_0000) ? 16'sh7fff : 16'sh8000;
            default:       sample = 16'sd0;
        endcase
    end

endmodule

// ===== rtl/waveform_oscillator_nco.sv =====
// Pipeline: stage one, output stage; a tick's result is registered in stage one and then in the output stage.
// Throughput: one tick per cycle while the output is not stalled; the sine ROM read is registered in stage one.
// The phase accumulator add and the ROM address are computed in the accept cycle.
// Reset clears the phase, restores waveform and increment defaults, empties both stages.
// The sine ROM is constant and needs no initialization pass.
module waveform_oscillator_nco
    import wnco_pkg::*;
#(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick_valid,
    output logic                       tick_stall,
    input  tick_t                      tick_data,
    output logic                       wave_valid,
    input  logic                       wave_stall,
    output wave_t                      wave_data,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

`include "waveform_oscillator_nco_assert.svh"

    localparam logic [SINE_ADDR_BITS:0] SINE_M = (SINE_ADDR_BITS + 1)'(1) << SINE_ADDR_BITS;

    logic [2:0]            waveform_reg;
    logic [31:0]           phase_inc_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [PHASE_BITS-1:0] phase_inc;
    logic [PHASE_BITS-1:0] phase_next;
    logic [31:0]           q;

    logic                      s1_valid_reg;
    logic [31:0]               s1_q_reg;
    logic [2:0]                s1_sel_reg;
    logic                      s1_last_reg;
    logic                      wave_valid_reg;
    wave_t                     wave_data_reg;

    logic                      out_en;
    logic                      s1_en;
    logic                      tick_accept;
    logic [SINE_ADDR_BITS+1:0] sine_idx;
    logic [SINE_ADDR_BITS:0]   sine_k;
    logic [SINE_ADDR_BITS:0]   sine_addr;
    logic [14:0]               sine_mag;
    logic signed [15:0]        shaped;

    assign out_en      = !wave_valid_reg || !wave_stall;
    assign s1_en       = !s1_valid_reg || out_en;
    assign tick_stall  = !s1_en;
    assign tick_accept = tick_valid && s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg  <= WAVEFORM_RESET;
            phase_inc_reg <= PHASE_INC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WAVEFORM:        waveform_reg  <= cfg_data[2:0];
                REG_PHASE_INCREMENT: phase_inc_reg <= cfg_data[31:0];
                default:             ;
            endcase
        end
    end

    assign phase_cur = tick_data.restart_phase ? '0 : phase_reg;

    generate
        if (PHASE_BITS > 32)
        begin : g_wide
            assign phase_inc = {{(PHASE_BITS - 32){1'b0}}, phase_inc_reg};
            assign q         = phase_cur[PHASE_BITS-1 -: 32];
        end
        else if (PHASE_BITS == 32)
        begin : g_exact
            assign phase_inc = phase_inc_reg;
            assign q         = phase_cur;
        end
        else
        begin : g_narrow
            assign phase_inc = phase_inc_reg[PHASE_BITS-1:0];
            assign q         = {phase_cur, {(32 - PHASE_BITS){1'b0}}};
        end
    endgenerate

    assign phase_next = phase_cur + phase_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (tick_accept)
            phase_reg <= phase_next;
    end

    // odd quadrants read the table backwards
    assign sine_idx  = q[31 -: SINE_ADDR_BITS + 2];
    assign sine_k    = {1'b0, sine_idx[SINE_ADDR_BITS-1:0]};
    assign sine_addr = sine_idx[SINE_ADDR_BITS] ? (SINE_M - sine_k) : sine_k;

    wnco_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine_rom (
        .clk  (clk),
        .en   (tick_accept),
        .addr (sine_addr),
        .data (sine_mag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_en)
            s1_valid_reg <= tick_valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            s1_q_reg    <= q;
            s1_sel_reg  <= waveform_reg;
            s1_last_reg <= tick_data.end_of_block;
        end
    end

    wnco_shape u_shape (
        .sel      (s1_sel_reg),
        .q        (s1_q_reg),
        .sine_mag (sine_mag),
        .sample   (shaped)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wave_valid_reg <= 1'b0;
        else if (out_en)
            wave_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s1_valid_reg)
        begin
            wave_data_reg.sample        <= shaped;
            wave_data_reg.last_in_block <= s1_last_reg;
        end
    end

    assign wave_valid = wave_valid_reg;
    assign wave_data  = wave_data_reg;

    // both stages full and output blocked: no new transfer may enter
    `WNCO_ASSERT_NEVER(a_full_accept, clk, rst_n, s1_valid_reg && wave_valid_reg && wave_stall && !tick_stall)
    `WNCO_ASSERT(a_out_held, clk, rst_n, wave_valid_reg && wave_stall |=> wave_valid_reg)
    `WNCO_ASSERT(a_s1_held, clk, rst_n, s1_valid_reg && wave_valid_reg && wave_stall |=> s1_valid_reg)
    `WNCO_ASSERT(a_phase_idle, clk, rst_n, !tick_accept |=> $stable(phase_reg))

endmodule
